>>> hdl/drs_pkg.sv
// Package: shared constants, codes and types for the disk request scheduler.
package drs_pkg;

  localparam int unsigned SlotsDef    = 16;
  localparam int unsigned CylBitsDef  = 16;
  localparam int unsigned TimeBitsDef = 32;
  localparam int unsigned OrdBits     = 32;

  localparam logic [0:0] OpInsert = 1'b0;
  localparam logic [0:0] OpGrant  = 1'b1;

  localparam logic [1:0] StInserted = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StGranted  = 2'd2;
  localparam logic [1:0] StNone     = 2'd3;

  localparam logic [1:0] PolFcfs  = 2'd0;
  localparam logic [1:0] PolSstf  = 2'd1;
  localparam logic [1:0] PolLook  = 2'd2;
  localparam logic [1:0] PolClook = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FIN,
    S_OUT
  } state_e;

endpackage

>>> hdl/disk_request_scheduler_core.sv
// Top level: disk request scheduler with a RAM-held request table.
//
// The block holds up to SLOTS pending cylinder requests. An insert
// (opcode 0) stores a request in the lowest free slot or reports the table
// full. A grant (opcode 1) carries the current time and streams the table
// out of RAM through its single read port one slot per cycle, keeping the best
// candidates for every policy branch at once, then frees the chosen slot and
// moves the head. One request is worked on at a time; the result sits in an
// output register, so the next request is accepted and scanned while it
// waits, and only the finish step holds until that register is free.
// Pending bits live in flip-flops and are cleared by reset, so no clearing
// pass is needed. policy_mode may only be written while the block is idle.
module disk_request_scheduler_core
  import drs_pkg::*;
#(
  parameter int unsigned SLOTS     = SlotsDef,
  parameter int unsigned CYL_BITS  = CylBitsDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser: [0] opcode
  input  logic [0:0]  s_axis_tuser,
  // tdata: [15:0] cylinder, [47:16] time_stamp
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [1:0] status, [5:2] slot, [21:6] granted_cylinder,
  //        [37:22] seek_distance, [69:38] wait_time, [70] sweep_up
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i
);

  localparam int unsigned IdxBits = $clog2(SLOTS);
  localparam int unsigned CntBits = $clog2(SLOTS + 1);
  localparam int unsigned EntW    = CYL_BITS + TIME_BITS + OrdBits;
  localparam logic [CYL_BITS-1:0] CylMax = '1;

  // one candidate tracker per scan flavor
  typedef struct packed {
    logic                found;
    logic [IdxBits-1:0]  idx;
    logic [CYL_BITS-1:0] key;
    logic [OrdBits-1:0]  age;
    logic [CYL_BITS-1:0] cyl;
    logic [TIME_BITS-1:0] arr;
  } cand_t;

  state_e state_q, state_d;
  logic [1:0]            policy_q;
  logic [SLOTS-1:0]      pend_q;
  logic [OrdBits-1:0]    seq_q;
  logic [CYL_BITS-1:0]   head_q;
  logic                  dir_q;
  logic                  op_q;
  logic [CYL_BITS-1:0]   cyl_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [CntBits-1:0]    cnt_q;
  logic [IdxBits-1:0]    ridx_q;
  logic [IdxBits-1:0]    sidx_q;
  logic                  rpend_q;
  cand_t                 c_any_q, c_dist_q, c_ge_q, c_le_q, c_lt_q, c_gt_q, c_low_q;
  cand_t                 c_any_d, c_dist_d, c_ge_d, c_le_d, c_lt_d, c_gt_d, c_low_d;
  logic                  ovalid_q;
  logic [71:0]           odata_q, odata_d;

  // RAM
  logic                  ram_we;
  logic [IdxBits-1:0]    ram_waddr, ram_raddr;
  logic [EntW-1:0]       ram_wdata, ram_rdata;

  drs_ram #(.Width(EntW), .Depth(SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [CYL_BITS-1:0]  e_cyl;
  logic [TIME_BITS-1:0] e_arr;
  logic [OrdBits-1:0]   e_ord, e_age;
  assign e_cyl = ram_rdata[CYL_BITS-1:0];
  assign e_arr = ram_rdata[CYL_BITS +: TIME_BITS];
  assign e_ord = ram_rdata[CYL_BITS+TIME_BITS +: OrdBits];
  assign e_age = seq_q - e_ord;

  // free slot search
  logic               has_free;
  logic [IdxBits-1:0] free_idx;
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!pend_q[i]) begin
        has_free = 1'b1;
        free_idx = IdxBits'(i);
      end
    end
  end

  function automatic cand_t upd(cand_t c, logic ok, logic [CYL_BITS-1:0] k,
                                logic [OrdBits-1:0] ag, logic [IdxBits-1:0] ix,
                                logic [CYL_BITS-1:0] cy, logic [TIME_BITS-1:0] ar);
    cand_t r;
    r = c;
    if (ok && (!c.found || k < c.key || (k == c.key && ag > c.age))) begin
      r.found = 1'b1; r.idx = ix; r.key = k; r.age = ag; r.cyl = cy; r.arr = ar;
    end
    return r;
  endfunction

  logic                 arrived, ge, le;
  logic [CYL_BITS-1:0]  gap;
  assign arrived = e_arr <= now_q;
  assign ge      = e_cyl >= head_q;
  assign le      = e_cyl <= head_q;
  assign gap     = ge ? e_cyl - head_q : head_q - e_cyl;

  // read data comes from a registered RAM read and lags the read pointer, so tag it with sidx_q
  always_comb begin
    c_any_d = c_any_q; c_dist_d = c_dist_q; c_ge_d = c_ge_q; c_le_d = c_le_q;
    c_lt_d = c_lt_q; c_gt_d = c_gt_q; c_low_d = c_low_q;
    if (state_q == S_IDLE) begin
      c_any_d = '0; c_dist_d = '0; c_ge_d = '0; c_le_d = '0;
      c_lt_d = '0; c_gt_d = '0; c_low_d = '0;
    end else if ((state_q == S_SCAN || state_q == S_LAST) && rpend_q) begin
      c_any_d  = upd(c_any_q, 1'b1, '0, e_age, sidx_q, e_cyl, e_arr);
      c_dist_d = upd(c_dist_q, arrived, gap, e_age, sidx_q, e_cyl, e_arr);
      c_ge_d   = upd(c_ge_q, arrived && ge, e_cyl, e_age, sidx_q, e_cyl, e_arr);
      c_gt_d   = upd(c_gt_q, arrived && !le, e_cyl, e_age, sidx_q, e_cyl, e_arr);
      c_low_d  = upd(c_low_q, arrived, e_cyl, e_age, sidx_q, e_cyl, e_arr);
      c_le_d   = upd(c_le_q, arrived && le, CylMax - e_cyl, e_age, sidx_q, e_cyl,
                     e_arr);
      c_lt_d   = upd(c_lt_q, arrived && !ge, CylMax - e_cyl, e_age, sidx_q, e_cyl,
                     e_arr);
    end
  end

  // final pick
  cand_t pick;
  logic  new_dir;
  always_comb begin
    pick    = '0;
    new_dir = dir_q;
    case (policy_q)
      PolFcfs: begin
        pick = c_any_q;
        if (c_any_q.arr > now_q) pick.found = 1'b0;
      end
      PolSstf: pick = c_dist_q;
      PolLook: begin
        if (dir_q) begin
          if (c_ge_q.found) pick = c_ge_q;
          else begin
            pick = c_lt_q;
            if (c_lt_q.found) new_dir = 1'b0;
          end
        end else begin
          if (c_le_q.found) pick = c_le_q;
          else begin
            pick = c_gt_q;
            if (c_gt_q.found) new_dir = 1'b1;
          end
        end
      end
      PolClook: pick = c_ge_q.found ? c_ge_q : c_low_q;
      default: pick = '0;
    endcase
  end

  logic [CYL_BITS-1:0] seek;
  assign seek = (pick.cyl >= head_q) ? pick.cyl - head_q : head_q - pick.cyl;

  // response word for the request being finished
  always_comb begin
    odata_d = '0;
    if (op_q == OpInsert) begin
      odata_d[1:0] = has_free ? StInserted : StFull;
      odata_d[5:2] = has_free ? 4'(free_idx) : 4'd0;
      odata_d[70]  = dir_q;
    end else if (pick.found) begin
      odata_d[1:0]   = StGranted;
      odata_d[5:2]   = 4'(pick.idx);
      odata_d[21:6]  = 16'(pick.cyl);
      odata_d[37:22] = 16'(seek);
      odata_d[69:38] = 32'(now_q - pick.arr);
      odata_d[70]    = new_dir;
    end else begin
      odata_d[1:0] = StNone;
      odata_d[70]  = dir_q;
    end
  end

  // finish only once the output register is free or being drained
  logic fin_go;
  assign fin_go = (state_q == S_FIN) && (!ovalid_q || m_axis_tready);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign ram_raddr = ridx_q;
  assign ram_we    = fin_go && (op_q == OpInsert) && has_free;
  assign ram_waddr = free_idx;
  assign ram_wdata = {seq_q, now_q, cyl_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = (s_axis_tuser[0] == OpGrant) ? S_SCAN : S_FIN;
      S_SCAN: if (cnt_q == CntBits'(SLOTS - 1)) state_d = S_LAST;
      S_LAST: state_d = S_FIN;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      policy_q <= PolFcfs;
      pend_q   <= '0;
      seq_q    <= '0;
      head_q   <= CYL_BITS'(1);
      dir_q    <= 1'b1;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      ridx_q   <= '0;
      rpend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) policy_q <= cfg_wdata_i;
      if (fin_go) ovalid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      // advance the read pointer; pending flag tracks the registered read
      rpend_q <= pend_q[ridx_q];
      if (in_fire) begin
        cnt_q  <= '0;
        ridx_q <= '0;
      end else if (state_q == S_SCAN) begin
        cnt_q  <= cnt_q + 1'b1;
        ridx_q <= (cnt_q == CntBits'(SLOTS - 1)) ? '0 : ridx_q + 1'b1;
      end
      if (fin_go) begin
        if (op_q == OpInsert) begin
          if (has_free) begin
            pend_q[free_idx] <= 1'b1;
            seq_q <= seq_q + 1'b1;
          end
        end else if (pick.found) begin
          pend_q[pick.idx] <= 1'b0;
          head_q <= pick.cyl;
          dir_q  <= new_dir;
        end
      end
    end
  end

  // scan index delayed to match the RAM read latency
  always_ff @(posedge clk_i) begin
    sidx_q <= ridx_q;
    if (in_fire) begin
      op_q  <= s_axis_tuser[0];
      cyl_q <= CYL_BITS'(s_axis_tdata[15:0]);
      now_q <= TIME_BITS'(s_axis_tdata[47:16]);
    end
    c_any_q <= c_any_d; c_dist_q <= c_dist_d; c_ge_q <= c_ge_d; c_le_q <= c_le_d;
    c_lt_q <= c_lt_d; c_gt_q <= c_gt_d; c_low_q <= c_low_d;
    if (fin_go) odata_q <= odata_d;
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
  a_out_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> ovalid_q) else $error("no result after finish");
  a_seq_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q != $past(seq_q) |-> $past(ram_we)) else $error("sequence moved without insert");
`endif

endmodule

>>> hdl/drs_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module drs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
